@@ design/cfb_pkg.sv @@
// Shared types, constants and the CRC-16/MODBUS byte update for the frame builder.
// No dependencies; used by cfb_result_gen and crc16_frame_builder.
package cfb_pkg;

  // Frame constants
  localparam logic [7:0]  HDR_BYTE  = 8'hFA;
  localparam logic [7:0]  TAIL_BYTE = 8'h0D;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;

  // Configuration register indexes
  localparam logic CFG_FRAME_OVERHEAD = 1'b0;
  localparam logic CFG_MAX_FRAME_LEN  = 1'b1;

  // Reset values of the configuration registers
  localparam logic [6:0]  OVERHEAD_RST = 7'd9;
  localparam logic [15:0] MAX_LEN_RST  = 16'd256;

  // Input item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_DATA  = 1'b1;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TOO_LARGE = 2'd1,
    STATUS_SEQ_ERR   = 2'd2
  } status_e;

  // Position within the result sequence of one item
  typedef enum logic [3:0] {
    SLOT_FIRST  = 4'd0,
    SLOT_LEN_LO = 4'd1,
    SLOT_LEN_HI = 4'd2,
    SLOT_DEV    = 4'd3,
    SLOT_CMD    = 4'd4,
    SLOT_MOD    = 4'd5,
    SLOT_CRC_LO = 4'd6,
    SLOT_CRC_HI = 4'd7,
    SLOT_TAIL   = 4'd8
  } slot_e;

  typedef struct packed {
    logic        kind;
    logic [7:0]  command;
    logic [7:0]  device_id;
    logic [7:0]  module_number;
    logic [15:0] body_len;
    logic [7:0]  payload_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       frame_end;
    logic [1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] crc;
    logic [15:0] bytes_left;
    logic        in_frame;
  } frame_state_t;

  typedef struct packed {
    slot_e next_slot;
    logic  last;
  } step_ctl_t;

  // Fold one byte into the reflected CRC-16/MODBUS accumulator
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ design/crc16_frame_builder.sv @@
// Top level of the length-prefixed frame builder with CRC-16/MODBUS trailer.
// Depends on cfb_pkg and cfb_result_gen.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | in_valid_i / in_ready_o  | in_data_i  (cfb_pkg::in_item_t)
//   out     | output    | out_valid_o / out_ready_i| out_data_o (cfb_pkg::out_item_t)
//   cfg     | input     | cfg_we_i                 | cfg_idx_i, cfg_wdata_i
//
// A start item gives 1, 6 or 9 results, a data item 1 or 4. The accepted item sits
// in an item register; unless the output stalls, one result per cycle is formed
// from it and loaded into the output register, so the next item transfers in the
// cycle its predecessor's last result is loaded.
// Reset clears control and frame state and restores the configuration registers.
// A stall on the output holds the output register and backs up into in_ready_o.
module crc16_frame_builder (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cfb_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cfb_pkg::out_item_t  out_data_o,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i
);

  logic [6:0]            overhead_q;
  logic [15:0]           max_len_q;
  cfb_pkg::in_item_t     item_q;
  logic                  busy_q, busy_d;
  cfb_pkg::slot_e        slot_q, slot_d;
  cfb_pkg::frame_state_t state_q, state_d;
  cfb_pkg::out_item_t    out_q;
  logic                  out_valid_q;

  cfb_pkg::out_item_t    gen_res;
  cfb_pkg::step_ctl_t    gen_ctl;

  logic adv;
  logic step;
  logic in_xfer;

  cfb_result_gen u_gen (
    .item_i     (item_q),
    .slot_i     (slot_q),
    .state_i    (state_q),
    .overhead_i (overhead_q),
    .max_len_i  (max_len_q),
    .res_o      (gen_res),
    .state_o    (state_d),
    .ctl_o      (gen_ctl)
  );

  // Output register free or draining this cycle
  assign adv        = !out_valid_q || out_ready_i;
  assign step       = busy_q && adv;
  assign in_ready_o = !busy_q || (adv && gen_ctl.last);
  assign in_xfer    = in_valid_i && in_ready_o;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Advance the slot sequence; a new item restarts it
  always_comb begin
    busy_d = busy_q;
    slot_d = slot_q;
    if (in_xfer) begin
      busy_d = 1'b1;
      slot_d = cfb_pkg::SLOT_FIRST;
    end else if (step) begin
      slot_d = gen_ctl.next_slot;
      if (gen_ctl.last) begin
        busy_d = 1'b0;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      overhead_q <= cfb_pkg::OVERHEAD_RST;
      max_len_q  <= cfb_pkg::MAX_LEN_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == cfb_pkg::CFG_FRAME_OVERHEAD) begin
        overhead_q <= cfg_wdata_i[6:0];
      end else begin
        max_len_q <= cfg_wdata_i;
      end
    end
  end

  // Control, frame state and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q           <= 1'b0;
      slot_q           <= cfb_pkg::SLOT_FIRST;
      state_q.crc      <= cfb_pkg::CRC_INIT;
      state_q.bytes_left <= 16'd0;
      state_q.in_frame <= 1'b0;
      out_valid_q      <= 1'b0;
    end else begin
      busy_q <= busy_d;
      slot_q <= slot_d;
      if (step) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item on transfer and the result on each step
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      item_q <= in_data_i;
    end
    if (step) begin
      out_q <= gen_res;
    end
  end

`ifndef SYNTHESIS
  // Busy drops only when the last result of an item is loaded
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !in_xfer && !(step && gen_ctl.last) |=> busy_q)
    else $error("item dropped before its last result");

  // The tail slot always finishes an item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && slot_q == cfb_pkg::SLOT_TAIL |-> gen_ctl.last)
    else $error("tail slot not marked last");

  // A clean frame end is always the tail byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.frame_end && out_q.status == cfb_pkg::STATUS_OK
      |-> out_q.tx_byte == cfb_pkg::TAIL_BYTE)
    else $error("frame end without tail byte");
`endif

endmodule

@@ design/cfb_result_gen.sv @@
// Result generator: forms the result of one slot of the current item and the next frame state.
// Depends on cfb_pkg. Purely combinational; registers live in crc16_frame_builder.
module cfb_result_gen (
  input  cfb_pkg::in_item_t     item_i,
  input  cfb_pkg::slot_e        slot_i,
  input  cfb_pkg::frame_state_t state_i,
  input  logic [6:0]            overhead_i,
  input  logic [15:0]           max_len_i,
  output cfb_pkg::out_item_t    res_o,
  output cfb_pkg::frame_state_t state_o,
  output cfb_pkg::step_ctl_t    ctl_o
);

  logic [16:0] flen_sum;
  logic        too_large;
  logic        feed;

  // Frame length at full width, so a large payload cannot wrap past the limit
  assign flen_sum  = 17'(overhead_i) + 17'(item_i.body_len);
  assign too_large = flen_sum > {1'b0, max_len_i};

  always_comb begin
    res_o.tx_byte   = 8'h00;
    res_o.frame_end = 1'b0;
    res_o.status    = cfb_pkg::STATUS_OK;
    state_o         = state_i;
    ctl_o.next_slot = cfb_pkg::SLOT_FIRST;
    ctl_o.last      = 1'b1;
    feed            = 1'b0;

    case (slot_i)
      cfb_pkg::SLOT_FIRST: begin
        if (item_i.kind == cfb_pkg::KIND_START) begin
          if (too_large) begin
            // drop any frame in progress and report the oversize
            res_o.frame_end  = 1'b1;
            res_o.status     = cfb_pkg::STATUS_TOO_LARGE;
            state_o.in_frame = 1'b0;
            state_o.bytes_left = 16'd0;
            state_o.crc      = cfb_pkg::CRC_INIT;
          end else begin
            res_o.tx_byte   = cfb_pkg::HDR_BYTE;
            state_o.crc     = cfb_pkg::CRC_INIT;
            ctl_o.next_slot = cfb_pkg::SLOT_LEN_LO;
            ctl_o.last      = 1'b0;
          end
        end else begin
          if (!state_i.in_frame || state_i.bytes_left == 16'd0) begin
            // data with no open frame: flag it, state unchanged
            res_o.frame_end = 1'b1;
            res_o.status    = cfb_pkg::STATUS_SEQ_ERR;
          end else begin
            res_o.tx_byte      = item_i.payload_byte;
            feed               = 1'b1;
            state_o.bytes_left = state_i.bytes_left - 16'd1;
            if (state_i.bytes_left == 16'd1) begin
              ctl_o.next_slot = cfb_pkg::SLOT_CRC_LO;
              ctl_o.last      = 1'b0;
            end
          end
        end
      end
      cfb_pkg::SLOT_LEN_LO: begin
        res_o.tx_byte   = flen_sum[7:0];
        feed            = 1'b1;
        ctl_o.next_slot = cfb_pkg::SLOT_LEN_HI;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_LEN_HI: begin
        res_o.tx_byte   = flen_sum[15:8];
        feed            = 1'b1;
        ctl_o.next_slot = cfb_pkg::SLOT_DEV;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_DEV: begin
        res_o.tx_byte   = item_i.device_id;
        feed            = 1'b1;
        ctl_o.next_slot = cfb_pkg::SLOT_CMD;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_CMD: begin
        res_o.tx_byte   = item_i.command;
        feed            = 1'b1;
        ctl_o.next_slot = cfb_pkg::SLOT_MOD;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_MOD: begin
        // header done: open the frame, close at once for an empty payload
        res_o.tx_byte      = item_i.module_number;
        feed               = 1'b1;
        state_o.bytes_left = item_i.body_len;
        state_o.in_frame   = 1'b1;
        if (item_i.body_len == 16'd0) begin
          ctl_o.next_slot = cfb_pkg::SLOT_CRC_LO;
          ctl_o.last      = 1'b0;
        end
      end
      cfb_pkg::SLOT_CRC_LO: begin
        res_o.tx_byte   = state_i.crc[7:0];
        ctl_o.next_slot = cfb_pkg::SLOT_CRC_HI;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_CRC_HI: begin
        res_o.tx_byte   = state_i.crc[15:8];
        ctl_o.next_slot = cfb_pkg::SLOT_TAIL;
        ctl_o.last      = 1'b0;
      end
      cfb_pkg::SLOT_TAIL: begin
        res_o.tx_byte    = cfb_pkg::TAIL_BYTE;
        res_o.frame_end  = 1'b1;
        state_o.in_frame = 1'b0;
        state_o.crc      = cfb_pkg::CRC_INIT;
      end
      default: begin
        ctl_o.last = 1'b1;
      end
    endcase

    // Fold the emitted byte into the CRC
    if (feed) begin
      state_o.crc = cfb_pkg::crc16_update(state_i.crc, res_o.tx_byte);
    end
  end

endmodule
